// ===== rtl/hhc_pkg.sv =====
// Package with shared widths, command codes and mode codes of the heater controller.
`timescale 1ns / 1ps
package hhc_pkg;

  // Stream widths
  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 5;
  localparam int M_TDATA_W = 104;
  localparam int M_TUSER_W = 1;
  localparam int SWITCH_W  = 8;

  // Command codes carried in func
  localparam logic [3:0] FUNC_SAMPLE    = 4'd0;
  localparam logic [3:0] FUNC_REPORT    = 4'd1;
  localparam logic [3:0] FUNC_NOOP      = 4'd2;
  localparam logic [3:0] FUNC_RST_CNT   = 4'd3;
  localparam logic [3:0] FUNC_ENABLE    = 4'd4;
  localparam logic [3:0] FUNC_DISABLE   = 4'd5;
  localparam logic [3:0] FUNC_SET_LIMIT = 4'd6;
  localparam logic [3:0] FUNC_FORCE_ON  = 4'd7;
  localparam logic [3:0] FUNC_FORCE_OFF = 4'd8;

  // Control modes
  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_COOLING  = 2'd1;
  localparam logic [1:0] MODE_HEATING  = 2'd2;
  localparam logic [1:0] MODE_DISABLED = 2'd3;

  // Result kinds
  localparam logic KIND_HEATER = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Heater command levels
  localparam logic [7:0] LEVEL_ON  = 8'hAA;
  localparam logic [7:0] LEVEL_OFF = 8'h00;

  // Threshold limits and reset values, sixteenths of a degree
  localparam logic signed [15:0] LIMIT_LO    = -16'sd640;
  localparam logic signed [15:0] LIMIT_HI    = 16'sd2000;
  localparam logic signed [11:0] LOW_RESET   = 12'sd0;
  localparam logic signed [11:0] HIGH_RESET  = 12'sd160;

endpackage

// ===== rtl/hysteresis_heater_controller_top.sv =====
// Hysteresis heater controller: sample and command decode with one result register.
`timescale 1ns / 1ps
// The block takes one item per clock while s_axis_tready is high: a temperature sample
// or a command, selected by func in s_axis_tuser. All decoding, threshold compares and
// counter updates sit in one level of logic ahead of a single result register, so a
// result (a heater command or a housekeeping report) appears on the master side in the
// cycle after its item is accepted, and items that cause no result leave nothing behind.
// The input is ready whenever the result register is empty or being drained in the same
// cycle, so the sustained rate is one item per cycle while the downstream side keeps
// taking results. Temperatures and thresholds are signed sixteenths of a degree.
// cfg_wdata written under cfg_we sets the heater switch number, held in a register.
module hysteresis_heater_controller_top (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration: heater switch number
  input  logic                           cfg_we,
  input  logic [hhc_pkg::SWITCH_W-1:0]   cfg_wdata,
  // Input items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: temp_raw[15:0], low_value[31:16], high_value[47:32]
  input  logic [hhc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: func[3:0], length_ok[4]
  input  logic [hhc_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  // Result items
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: heater_level[7:0], cmd_count[15:8], err_count[23:16], control_enabled[24],
  //   control_mode[26:25], heater_on[27], temperature[43:28], low_threshold[55:44],
  //   high_threshold[67:56], on_events[83:68], off_events[99:84], zero fill[103:100]
  output logic [hhc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // tuser: kind[0]
  output logic [hhc_pkg::M_TUSER_W-1:0]  m_axis_tuser
);
  import hhc_pkg::*;

  // Controller state
  logic [SWITCH_W-1:0] heater_switch;
  logic [1:0]          mode, mode_next;
  logic                enabled, enabled_next;
  logic                heater, heater_next;
  logic signed [15:0]  last_temp, last_temp_next;
  logic signed [11:0]  low_level, low_level_next;
  logic signed [11:0]  high_level, high_level_next;
  logic [7:0]          accepted_cnt, accepted_cnt_next;
  logic [7:0]          error_cnt, error_cnt_next;
  logic [15:0]         on_cnt, on_cnt_next;
  logic [15:0]         off_cnt, off_cnt_next;

  // Result register
  logic                  res_valid_next;
  logic [M_TDATA_W-1:0]  res_data_next;
  logic                  res_kind_next;

  // Input fields
  logic [3:0]          func;
  logic                length_ok;
  logic signed [15:0]  temp_raw;
  logic signed [15:0]  low_value;
  logic signed [15:0]  high_value;
  logic signed [15:0]  low_ext;
  logic signed [15:0]  high_ext;
  logic                limits_bad;
  logic                accept;

  assign func       = s_axis_tuser[3:0];
  assign length_ok  = s_axis_tuser[4];
  assign temp_raw   = s_axis_tdata[15:0];
  assign low_value  = s_axis_tdata[31:16];
  assign high_value = s_axis_tdata[47:32];

  assign low_ext  = {{4{low_level[11]}}, low_level};
  assign high_ext = {{4{high_level[11]}}, high_level};
  assign limits_bad = (low_value >= high_value) || (low_value < LIMIT_LO) ||
                      (high_value > LIMIT_HI);

  // Take a new item whenever the result register is free or draining
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Decode one item and work out the next state and its result
  always_comb begin
    mode_next         = mode;
    enabled_next      = enabled;
    heater_next       = heater;
    last_temp_next    = last_temp;
    low_level_next    = low_level;
    high_level_next   = high_level;
    accepted_cnt_next = accepted_cnt;
    error_cnt_next    = error_cnt;
    on_cnt_next       = on_cnt;
    off_cnt_next      = off_cnt;
    res_valid_next    = 1'b0;
    res_kind_next     = KIND_HEATER;
    res_data_next     = '0;

    if (func == FUNC_SAMPLE) begin
      last_temp_next = temp_raw;
      if (enabled) begin
        if (mode == MODE_IDLE || mode == MODE_COOLING) begin
          if (temp_raw < low_ext) begin
            heater_next    = 1'b1;
            mode_next      = MODE_HEATING;
            res_valid_next = 1'b1;
            res_data_next[7:0] = LEVEL_ON;
            if (!heater) begin
              on_cnt_next = on_cnt + 16'd1;
            end
          end else begin
            mode_next = MODE_COOLING;
          end
        end else if (mode == MODE_HEATING) begin
          if (temp_raw > high_ext) begin
            heater_next    = 1'b0;
            mode_next      = MODE_COOLING;
            res_valid_next = 1'b1;
            res_data_next[7:0] = LEVEL_OFF;
            if (heater) begin
              off_cnt_next = off_cnt + 16'd1;
            end
          end
        end
      end
    end else if (func == FUNC_REPORT) begin
      // Report the state as it stands; nothing changes
      res_valid_next       = 1'b1;
      res_kind_next        = KIND_REPORT;
      res_data_next[7:0]   = LEVEL_OFF;
      res_data_next[15:8]  = accepted_cnt;
      res_data_next[23:16] = error_cnt;
      res_data_next[24]    = enabled;
      res_data_next[26:25] = mode;
      res_data_next[27]    = heater;
      res_data_next[43:28] = last_temp;
      res_data_next[55:44] = low_level;
      res_data_next[67:56] = high_level;
      res_data_next[83:68] = on_cnt;
      res_data_next[99:84] = off_cnt;
    end else if (func > FUNC_FORCE_OFF || !length_ok) begin
      // Unknown code or wrong length: count the error only
      error_cnt_next = error_cnt + 8'd1;
    end else begin
      accepted_cnt_next = accepted_cnt + 8'd1;
      unique case (func)
        FUNC_NOOP: begin
        end
        FUNC_RST_CNT: begin
          accepted_cnt_next = '0;
          error_cnt_next    = '0;
          on_cnt_next       = '0;
          off_cnt_next      = '0;
        end
        FUNC_ENABLE: begin
          enabled_next = 1'b1;
          mode_next    = MODE_IDLE;
        end
        FUNC_DISABLE: begin
          enabled_next = 1'b0;
          mode_next    = MODE_DISABLED;
        end
        FUNC_SET_LIMIT: begin
          if (limits_bad) begin
            error_cnt_next = error_cnt + 8'd1;
          end else begin
            low_level_next  = low_value[11:0];
            high_level_next = high_value[11:0];
          end
        end
        FUNC_FORCE_ON: begin
          heater_next        = 1'b1;
          res_valid_next     = 1'b1;
          res_data_next[7:0] = LEVEL_ON;
        end
        default: begin
          heater_next        = 1'b0;
          res_valid_next     = 1'b1;
          res_data_next[7:0] = LEVEL_OFF;
        end
      endcase
    end
  end

  // Hold the configured switch number
  always_ff @(posedge clk) begin
    if (rst) begin
      heater_switch <= '0;
    end else if (cfg_we) begin
      heater_switch <= cfg_wdata;
    end
  end

  // Advance the controller state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      enabled      <= 1'b1;
      heater       <= 1'b0;
      last_temp    <= '0;
      low_level    <= LOW_RESET;
      high_level   <= HIGH_RESET;
      accepted_cnt <= '0;
      error_cnt    <= '0;
      on_cnt       <= '0;
      off_cnt      <= '0;
    end else if (accept) begin
      mode         <= mode_next;
      enabled      <= enabled_next;
      heater       <= heater_next;
      last_temp    <= last_temp_next;
      low_level    <= low_level_next;
      high_level   <= high_level_next;
      accepted_cnt <= accepted_cnt_next;
      error_cnt    <= error_cnt_next;
      on_cnt       <= on_cnt_next;
      off_cnt      <= off_cnt_next;
    end
  end

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= res_valid_next;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata    <= res_data_next;
      m_axis_tuser[0] <= res_kind_next;
    end
  end

`ifndef SYNTHESIS
  // Disabled mode goes hand in hand with control switched off
  a_mode_enable: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_DISABLED) == !enabled)
    else $error("mode and enable flag disagree");

  // A heater command carries only a valid level
  a_heater_cmd: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0] == KIND_HEATER) |->
      ((m_axis_tdata[7:0] == LEVEL_ON || m_axis_tdata[7:0] == LEVEL_OFF) &&
       m_axis_tdata[M_TDATA_W-1:8] == '0))
    else $error("malformed heater command");

  // Event counters and the heater flag move only on accepted items
  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(on_cnt) && $stable(off_cnt) && $stable(heater)))
    else $error("state changed without an item");

  // A result raised by an item matches the heater it left behind
  a_level_heater: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid_next && res_kind_next == KIND_HEATER) |=>
      ((m_axis_tdata[7:0] == LEVEL_ON) == heater))
    else $error("heater command does not match heater state");
`endif

endmodule
